FILE: rtl/cslvr_pkg.sv
// Shared types, widths and constants for the CPU soft-limit vote regulator.
// Used by the shared divider and by the top level; depends on nothing else.

package cslvr_pkg;

    // Field widths.
    localparam int TIME_W     = 48;   // timestamps and CPU time in microseconds
    localparam int Q_W        = 16;   // Q8.8 values
    localparam int FRAC_W     = 8;    // fraction bits of a Q8.8 value
    localparam int SF_W       = 17;   // smoothing factor, Q0.16 up to 1.0
    localparam int THR_W      = 5;    // vote threshold
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    // Vote window.
    localparam int VOTE_WINDOW = 16;
    localparam int VOTE_IDX_W  = (VOTE_WINDOW > 1) ? $clog2(VOTE_WINDOW) : 1;
    localparam int VOTE_CNT_W  = $clog2(VOTE_WINDOW + 1);
    localparam int VOTE_SUM_W  = VOTE_CNT_W + 1;
    localparam int VOTE_CMP_W  = ((VOTE_SUM_W > THR_W + 1) ? VOTE_SUM_W : THR_W + 1) + 1;

    // Limit scaling coefficients, Q8.8.
    localparam int INCREASE_COEF = 371;
    localparam int DECREASE_COEF = 205;

    // Shared multiplier: a 17 bit operand times a 16 bit operand.
    localparam int MUL_W = SF_W + Q_W;

    // Divider iteration count.
    localparam int DIV_CNT_W = $clog2(Q_W);

    // Smoothing constants.
    localparam logic [SF_W-1:0] SF_ONE     = SF_W'(1) << Q_W;
    localparam logic [MUL_W:0]  ROUND_HALF = (MUL_W + 1)'(1) << (Q_W - 1);

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_HARD_LIMIT       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_LIMIT        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SMOOTHING_FACTOR = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LOWER_BOUND      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UPPER_BOUND      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_VOTE_THRESHOLD   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_RECLAIM_ENABLE   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_START_TIME       = 3'd7;

    // Register reset values.
    localparam logic [Q_W-1:0]    HARD_LIMIT_RST       = 16'd256;
    localparam logic [Q_W-1:0]    MIN_LIMIT_RST        = 16'd256;
    localparam logic [SF_W-1:0]   SMOOTHING_FACTOR_RST = 17'd6554;
    localparam logic [Q_W-1:0]    LOWER_BOUND_RST      = 16'd128;
    localparam logic [Q_W-1:0]    UPPER_BOUND_RST      = 16'd230;
    localparam logic [THR_W-1:0]  VOTE_THRESHOLD_RST   = 5'd5;
    localparam logic [TIME_W-1:0] START_TIME_RST       = '0;

    // Vote codes as stored in the window.
    typedef enum logic [1:0] {
        VOTE_KEEP = 2'd0,
        VOTE_INC  = 2'd1,
        VOTE_DEC  = 2'd2
    } vote_t;

    // Tick status codes.
    typedef enum logic [1:0] {
        TICK_EVALUATED   = 2'd0,
        TICK_NOT_STARTED = 2'd1,
        TICK_READ_FAILED = 2'd2,
        TICK_PRIMING     = 2'd3
    } tick_status_t;

    // Request to the shared divider: quotient = min((num << 8) / den, 65535).
    typedef struct packed {
        logic              start;
        logic [TIME_W-1:0] num;
        logic [TIME_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic           done;
        logic [Q_W-1:0] quotient;
    } div_rsp_t;

endpackage

FILE: rtl/cslvr_div.sv
// Shared restoring divider of the regulator: saturating Q8.8 quotient of two 48 bit values.
// Depends on cslvr_pkg.

module cslvr_div
    import cslvr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                 run_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 sat_reg;
    logic [TIME_W-1:0]    den_reg;
    logic [TIME_W-1:0]    rem_reg;
    logic [Q_W-1:0]       bits_reg;
    logic [Q_W-1:0]       q_reg;

    logic [TIME_W+Q_W-1:0] sat_lhs;
    logic [TIME_W+Q_W-1:0] sat_rhs;
    logic [TIME_W:0]       trial;
    logic [TIME_W:0]       diff;
    logic                  fits;

    // The quotient overflows 16 bits exactly when (num << 8) >= (den << 16).
    // A zero divisor lands here as well.
    assign sat_lhs = {{(Q_W - FRAC_W){1'b0}}, req.num, {FRAC_W{1'b0}}};
    assign sat_rhs = {req.den, {Q_W{1'b0}}};

    // One quotient bit per cycle.
    assign trial = {rem_reg, bits_reg[Q_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = (trial >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= DIV_CNT_W'(Q_W - 1);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            sat_reg  <= (sat_lhs >= sat_rhs);
            den_reg  <= req.den;
            rem_reg  <= req.num >> (Q_W - FRAC_W);
            bits_reg <= {req.num[Q_W-FRAC_W-1:0], {FRAC_W{1'b0}}};
            q_reg    <= '0;
        end
        else if (run_reg)
        begin
            rem_reg  <= fits ? diff[TIME_W-1:0] : trial[TIME_W-1:0];
            bits_reg <= {bits_reg[Q_W-2:0], 1'b0};
            q_reg    <= {q_reg[Q_W-2:0], fits};
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = sat_reg ? {Q_W{1'b1}} : q_reg;

endmodule

FILE: rtl/cpu_soft_limit_vote_regulator_top.sv
// Top level of the CPU soft-limit vote regulator: sequencer, vote window and shared multiplier.
// Depends on cslvr_pkg and instantiates cslvr_div.

// Each input transfer is one check tick and yields exactly one output transfer. The block
// works on one tick at a time and holds in_stall high until that tick's result has been
// placed in the output register, which then waits for the consumer on its own while the
// next tick is already taken. A tick that is ignored (before start_time or with a failed
// reading) or that only primes the sample registers goes from S_CHECK straight to S_FINISH.
// An evaluated tick uses the shared restoring divider, which makes two 16-step passes per
// tick, one for the usage and one for the usage to soft limit ratio, and the shared 17x16
// multiplier, used in sequence twice for the average and once for the limit scaling (the
// first smoothing seeds the average with hard_limit instead of computing it). A result
// that cannot leave because the previous one is still stalled at the output waits in
// S_FINISH. Both divisions saturate at 65535, which also covers a zero time delta and a
// zero soft limit. Votes go into a window of VOTE_WINDOW entries; once full, a vote sum
// beyond vote_threshold in either direction scales the soft limit (unless reclaim is on
// and the change is refused) and clears the window, otherwise the oldest vote leaves it.
// Configuration is to be written only while no tick is in progress; the block itself
// does not enforce this. A write to hard_limit also reloads the soft limit. No clearing
// pass is needed after reset.

module cpu_soft_limit_vote_regulator_top
    import cslvr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [TIME_W-1:0]     now_time,
    input  logic [TIME_W-1:0]     total_cpu,
    input  logic                  read_ok,
    input  logic                  change_accepted,

    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [Q_W-1:0]        soft_limit,
    output logic [Q_W-1:0]        smoothed_usage,
    output logic                  usage_valid,
    output logic                  limit_changed,
    output logic                  change_refused,
    output logic [1:0]            tick_status
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_DIVU_GO,
        S_DIVU_WAIT,
        S_MUL1,
        S_MUL2,
        S_SUM,
        S_DIVR_GO,
        S_DIVR_WAIT,
        S_DECIDE,
        S_APPLY,
        S_FINISH
    } state_t;

    // Configuration registers.
    logic [Q_W-1:0]    hard_limit_reg;
    logic [Q_W-1:0]    min_limit_reg;
    logic [SF_W-1:0]   smoothing_factor_reg;
    logic [Q_W-1:0]    lower_bound_reg;
    logic [Q_W-1:0]    upper_bound_reg;
    logic [THR_W-1:0]  vote_threshold_reg;
    logic              reclaim_enable_reg;
    logic [TIME_W-1:0] start_time_reg;

    // Control state.
    state_t                         state_reg;
    logic                           started_reg;
    logic                           have_last_reg;
    logic                           smoothed_present_reg;
    logic [Q_W-1:0]                 smoothed_reg;
    logic [Q_W-1:0]                 soft_limit_reg;
    logic [VOTE_IDX_W-1:0]          vote_head_reg;
    logic [VOTE_CNT_W-1:0]          vote_count_reg;
    logic signed [VOTE_SUM_W-1:0]   vote_sum_reg;
    logic                           out_valid_reg;

    // Working registers of one tick.
    logic [TIME_W-1:0]  last_time_reg;
    logic [TIME_W-1:0]  last_cpu_reg;
    logic [TIME_W-1:0]  now_reg;
    logic [TIME_W-1:0]  cpu_reg;
    logic               ok_reg;
    logic               accepted_reg;
    logic [TIME_W-1:0]  dt_reg;
    logic [TIME_W-1:0]  dc_reg;
    logic [Q_W-1:0]     usage_reg;
    logic [MUL_W-1:0]   prod_reg;
    logic [MUL_W-1:0]   acc_reg;
    logic               inc_dir_reg;
    tick_status_t       status_reg;
    logic               changed_reg;
    logic               refused_reg;

    // Output register payload.
    logic [Q_W-1:0]     res_soft_limit_reg;
    logic [Q_W-1:0]     res_smoothed_reg;
    logic               res_usage_valid_reg;
    logic               res_changed_reg;
    logic               res_refused_reg;
    tick_status_t       res_status_reg;

    // Vote window storage; entries are only read after they were written.
    logic [1:0] vote_ring [VOTE_WINDOW];

    localparam logic signed [VOTE_SUM_W-1:0] SUM_ONE = VOTE_SUM_W'(1);

    div_req_t div_req;
    div_rsp_t div_rsp;

    logic                         in_xfer;
    logic                         out_free;
    logic                         start_hit;
    logic [SF_W-1:0]              f_eff;
    logic [SF_W-1:0]              mul_a;
    logic [Q_W-1:0]               mul_b;
    logic [MUL_W:0]               smooth_total;
    vote_t                        new_vote;
    vote_t                        old_vote;
    logic                         window_full;
    logic [VOTE_IDX_W:0]          wr_sum;
    logic [VOTE_IDX_W-1:0]        wr_idx;
    logic                         ring_we;
    logic signed [VOTE_CMP_W-1:0] sum_ext;
    logic signed [VOTE_CMP_W-1:0] thr_ext;
    logic signed [VOTE_CMP_W-1:0] cnt_ext;
    logic                         want_inc;
    logic                         want_dec;
    logic [Q_W-1:0]               low_clamp;
    logic [MUL_W-FRAC_W-1:0]      scaled;
    logic [Q_W-1:0]               proposal;

    assign in_xfer  = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign out_free = !out_valid_reg || !out_stall;

    assign start_hit = started_reg || (now_reg >= start_time_reg);

    // A smoothing factor above 1.0 counts as 1.0.
    assign f_eff = smoothing_factor_reg[SF_W-1] ? SF_ONE : smoothing_factor_reg;

    // Operands of the shared multiplier.
    always_comb
    begin
        mul_a = f_eff;
        mul_b = usage_reg;
        unique case (state_reg)
            S_MUL2:
            begin
                mul_a = SF_ONE - f_eff;
                mul_b = smoothed_reg;
            end
            S_DECIDE:
            begin
                mul_a = want_inc ? SF_W'(INCREASE_COEF) : SF_W'(DECREASE_COEF);
                mul_b = soft_limit_reg;
            end
            default:
            begin
                mul_a = f_eff;
                mul_b = usage_reg;
            end
        endcase
    end

    assign smooth_total = {1'b0, acc_reg} + {1'b0, prod_reg} + ROUND_HALF;

    // Divider operands: usage in the first pass, ratio in the second.
    always_comb
    begin
        div_req.start = (state_reg == S_DIVU_GO) || (state_reg == S_DIVR_GO);
        if (state_reg == S_DIVR_GO)
        begin
            div_req.num = TIME_W'(smoothed_reg);
            div_req.den = TIME_W'(soft_limit_reg);
        end
        else
        begin
            div_req.num = dc_reg;
            div_req.den = dt_reg;
        end
    end

    cslvr_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Vote cast by the ratio.
    always_comb
    begin
        if (div_rsp.quotient < lower_bound_reg)
        begin
            new_vote = VOTE_DEC;
        end
        else if (div_rsp.quotient > upper_bound_reg)
        begin
            new_vote = VOTE_INC;
        end
        else
        begin
            new_vote = VOTE_KEEP;
        end
    end

    assign window_full = (vote_count_reg >= VOTE_CNT_W'(VOTE_WINDOW));

    // The write slot follows the oldest entry by the fill count, modulo the window.
    assign wr_sum  = (VOTE_IDX_W + 1)'(vote_head_reg) + (VOTE_IDX_W + 1)'(vote_count_reg);
    assign wr_idx  = (wr_sum >= (VOTE_IDX_W + 1)'(VOTE_WINDOW))
                   ? VOTE_IDX_W'(wr_sum - (VOTE_IDX_W + 1)'(VOTE_WINDOW))
                   : VOTE_IDX_W'(wr_sum);
    assign ring_we = (state_reg == S_DIVR_WAIT) && div_rsp.done && !window_full;

    always_comb
    begin
        unique case (vote_ring[vote_head_reg])
            VOTE_INC:  old_vote = VOTE_INC;
            VOTE_DEC:  old_vote = VOTE_DEC;
            default:   old_vote = VOTE_KEEP;
        endcase
    end

    assign sum_ext  = VOTE_CMP_W'(vote_sum_reg);
    assign thr_ext  = VOTE_CMP_W'(vote_threshold_reg);
    assign cnt_ext  = VOTE_CMP_W'(vote_count_reg);
    assign want_inc = (sum_ext > thr_ext);
    assign want_dec = (sum_ext < -thr_ext);

    // Scaled limit and its clamp; the lower clamp never exceeds hard_limit.
    assign low_clamp = (min_limit_reg < hard_limit_reg) ? min_limit_reg : hard_limit_reg;
    assign scaled    = prod_reg[MUL_W-1:FRAC_W];

    always_comb
    begin
        if (inc_dir_reg)
        begin
            proposal = (scaled > (MUL_W - FRAC_W)'(hard_limit_reg))
                     ? hard_limit_reg : scaled[Q_W-1:0];
        end
        else
        begin
            proposal = (scaled < (MUL_W - FRAC_W)'(low_clamp))
                     ? low_clamp : scaled[Q_W-1:0];
        end
    end

    // Sequencer, configuration registers and all control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hard_limit_reg       <= HARD_LIMIT_RST;
            min_limit_reg        <= MIN_LIMIT_RST;
            smoothing_factor_reg <= SMOOTHING_FACTOR_RST;
            lower_bound_reg      <= LOWER_BOUND_RST;
            upper_bound_reg      <= UPPER_BOUND_RST;
            vote_threshold_reg   <= VOTE_THRESHOLD_RST;
            reclaim_enable_reg   <= 1'b0;
            start_time_reg       <= START_TIME_RST;
            state_reg            <= S_IDLE;
            started_reg          <= 1'b0;
            have_last_reg        <= 1'b0;
            last_time_reg        <= '0;
            last_cpu_reg         <= '0;
            smoothed_present_reg <= 1'b0;
            smoothed_reg         <= '0;
            soft_limit_reg       <= HARD_LIMIT_RST;
            vote_head_reg        <= '0;
            vote_count_reg       <= '0;
            vote_sum_reg         <= '0;
            out_valid_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_HARD_LIMIT:
                    begin
                        hard_limit_reg <= cfg_data[Q_W-1:0];
                        soft_limit_reg <= cfg_data[Q_W-1:0];
                    end
                    REG_MIN_LIMIT:        min_limit_reg        <= cfg_data[Q_W-1:0];
                    REG_SMOOTHING_FACTOR: smoothing_factor_reg <= cfg_data[SF_W-1:0];
                    REG_LOWER_BOUND:      lower_bound_reg      <= cfg_data[Q_W-1:0];
                    REG_UPPER_BOUND:      upper_bound_reg      <= cfg_data[Q_W-1:0];
                    REG_VOTE_THRESHOLD:   vote_threshold_reg   <= cfg_data[THR_W-1:0];
                    REG_RECLAIM_ENABLE:   reclaim_enable_reg   <= cfg_data[0];
                    REG_START_TIME:       start_time_reg       <= cfg_data[TIME_W-1:0];
                    default:
                    begin
                    end
                endcase
            end

            if (state_reg == S_FINISH && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_xfer)
                    begin
                        state_reg <= S_CHECK;
                    end
                end

                S_CHECK:
                begin
                    started_reg <= start_hit;
                    if (!start_hit || !ok_reg)
                    begin
                        state_reg <= S_FINISH;
                    end
                    else if (!have_last_reg)
                    begin
                        have_last_reg <= 1'b1;
                        last_time_reg <= now_reg;
                        last_cpu_reg  <= cpu_reg;
                        state_reg     <= S_FINISH;
                    end
                    else
                    begin
                        last_time_reg <= now_reg;
                        last_cpu_reg  <= cpu_reg;
                        state_reg     <= S_DIVU_GO;
                    end
                end

                S_DIVU_GO:
                begin
                    state_reg <= S_DIVU_WAIT;
                end

                S_DIVU_WAIT:
                begin
                    if (div_rsp.done)
                    begin
                        if (smoothed_present_reg)
                        begin
                            state_reg <= S_MUL1;
                        end
                        else
                        begin
                            // The first average starts from the hard limit.
                            smoothed_reg         <= hard_limit_reg;
                            smoothed_present_reg <= 1'b1;
                            state_reg            <= S_DIVR_GO;
                        end
                    end
                end

                S_MUL1:
                begin
                    state_reg <= S_MUL2;
                end

                S_MUL2:
                begin
                    state_reg <= S_SUM;
                end

                S_SUM:
                begin
                    smoothed_reg <= smooth_total[2*Q_W-1:Q_W];
                    state_reg    <= S_DIVR_GO;
                end

                S_DIVR_GO:
                begin
                    state_reg <= S_DIVR_WAIT;
                end

                S_DIVR_WAIT:
                begin
                    if (div_rsp.done)
                    begin
                        if (!window_full)
                        begin
                            vote_count_reg <= vote_count_reg + 1'b1;
                            if (new_vote == VOTE_INC)
                            begin
                                vote_sum_reg <= vote_sum_reg + SUM_ONE;
                            end
                            else if (new_vote == VOTE_DEC)
                            begin
                                vote_sum_reg <= vote_sum_reg - SUM_ONE;
                            end
                        end
                        state_reg <= S_DECIDE;
                    end
                end

                S_DECIDE:
                begin
                    if (!window_full)
                    begin
                        state_reg <= S_FINISH;
                    end
                    else if (want_inc || want_dec)
                    begin
                        state_reg <= S_APPLY;
                    end
                    else
                    begin
                        // No decision: the oldest vote leaves the window.
                        if (old_vote == VOTE_INC)
                        begin
                            vote_sum_reg <= vote_sum_reg - SUM_ONE;
                        end
                        else if (old_vote == VOTE_DEC)
                        begin
                            vote_sum_reg <= vote_sum_reg + SUM_ONE;
                        end
                        vote_head_reg  <= (vote_head_reg == VOTE_IDX_W'(VOTE_WINDOW - 1))
                                        ? '0 : vote_head_reg + 1'b1;
                        vote_count_reg <= vote_count_reg - 1'b1;
                        state_reg      <= S_FINISH;
                    end
                end

                S_APPLY:
                begin
                    // A decision always clears the window, even when it is refused.
                    vote_head_reg  <= '0;
                    vote_count_reg <= '0;
                    vote_sum_reg   <= '0;
                    if (proposal != soft_limit_reg && (!reclaim_enable_reg || accepted_reg))
                    begin
                        soft_limit_reg <= proposal;
                    end
                    state_reg <= S_FINISH;
                end

                S_FINISH:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Per-tick working registers and the output payload.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            now_reg      <= now_time;
            cpu_reg      <= total_cpu;
            ok_reg       <= read_ok;
            accepted_reg <= change_accepted;
        end

        unique case (state_reg)
            S_CHECK:
            begin
                dt_reg      <= now_reg - last_time_reg;
                dc_reg      <= cpu_reg - last_cpu_reg;
                changed_reg <= 1'b0;
                refused_reg <= 1'b0;
                if (!start_hit)
                begin
                    status_reg <= TICK_NOT_STARTED;
                end
                else if (!ok_reg)
                begin
                    status_reg <= TICK_READ_FAILED;
                end
                else if (!have_last_reg)
                begin
                    status_reg <= TICK_PRIMING;
                end
                else
                begin
                    status_reg <= TICK_EVALUATED;
                end
            end
            S_DIVU_WAIT:
            begin
                if (div_rsp.done)
                begin
                    usage_reg <= div_rsp.quotient;
                end
            end
            S_MUL1:
            begin
                prod_reg <= mul_a * mul_b;
            end
            S_MUL2:
            begin
                acc_reg  <= prod_reg;
                prod_reg <= mul_a * mul_b;
            end
            S_DECIDE:
            begin
                inc_dir_reg <= want_inc;
                prod_reg    <= mul_a * mul_b;
            end
            S_APPLY:
            begin
                if (proposal != soft_limit_reg)
                begin
                    changed_reg <= !reclaim_enable_reg || accepted_reg;
                    refused_reg <= reclaim_enable_reg && !accepted_reg;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    res_soft_limit_reg  <= soft_limit_reg;
                    res_smoothed_reg    <= smoothed_present_reg ? smoothed_reg : '0;
                    res_usage_valid_reg <= smoothed_present_reg;
                    res_changed_reg     <= changed_reg;
                    res_refused_reg     <= refused_reg;
                    res_status_reg      <= status_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            vote_ring[wr_idx] <= new_vote;
        end
    end

    assign out_valid      = out_valid_reg;
    assign soft_limit     = res_soft_limit_reg;
    assign smoothed_usage = res_smoothed_reg;
    assign usage_valid    = res_usage_valid_reg;
    assign limit_changed  = res_changed_reg;
    assign change_refused = res_refused_reg;
    assign tick_status    = res_status_reg;

    // Between ticks the window is never left full.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (vote_count_reg < VOTE_CNT_W'(VOTE_WINDOW)))
        else $error("vote window left full between ticks");

    // The vote sum can never exceed the number of votes held, in either direction.
    assert property (@(posedge clk) disable iff (!rst_n)
        (sum_ext <= cnt_ext) && (sum_ext >= -cnt_ext))
        else $error("vote sum out of range of the vote count");

    // A tick cannot both change the limit and report a refusal.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(limit_changed && change_refused))
        else $error("limit change and refusal reported together");

    // Without a smoothed value the reported usage is zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !usage_valid) |-> (smoothed_usage == '0))
        else $error("usage reported without a smoothed value");

    // A divider result only arrives while the sequencer waits for one.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> ((state_reg == S_DIVU_WAIT) || (state_reg == S_DIVR_WAIT)))
        else $error("divider result outside a wait state");

endmodule

FILE: tb/tb_cpu_soft_limit_vote_regulator_top.sv
// Self-checking testbench for the CPU soft-limit vote regulator top level.
// Holds its own model of the regulator in a small scoreboard class and needs only
// cslvr_pkg and cpu_soft_limit_vote_regulator_top, which brings in cslvr_div.
`timescale 1ns / 100ps

module tb_cpu_soft_limit_vote_regulator_top
    import cslvr_pkg::*;
();

    // Run parameters. The watchdog limit is far above the longest legal quiet stretch:
    // the longest sender gap, an evaluated tick and the longest receiver stall in a row,
    // or a full set of register writes between phases.
    localparam int HALF_PERIOD  = 6;
    localparam int RESET_CYCLES = 7;
    localparam int PHASE_COUNT  = 10;
    localparam int PHASE_TICKS  = 123;
    localparam int IDLE_LIMIT   = 1000;
    localparam int DRAIN_CYCLES = 60;

    // One check tick as it crosses the input channel.
    typedef struct {
        logic [TIME_W-1:0] now_time;
        logic [TIME_W-1:0] total_cpu;
        logic              read_ok;
        logic              change_accepted;
    } tick_t;

    // One result as it crosses the output channel.
    typedef struct {
        logic [Q_W-1:0] soft_limit;
        logic [Q_W-1:0] smoothed_usage;
        logic           usage_valid;
        logic           limit_changed;
        logic           change_refused;
        tick_status_t   tick_status;
    } tick_result_t;

    // The scoreboard keeps its own copy of the registers and of the regulator state.
    // Every tick that transfers in is run through the model at once and its result
    // queued; every result that transfers out is checked against the oldest entry.
    class soft_limit_tracker;
        logic [Q_W-1:0]    hard_limit_r;
        logic [Q_W-1:0]    min_limit_r;
        logic [SF_W-1:0]   smoothing_r;
        logic [Q_W-1:0]    lower_bound_r;
        logic [Q_W-1:0]    upper_bound_r;
        logic [THR_W-1:0]  threshold_r;
        logic              reclaim_r;
        logic [TIME_W-1:0] start_time_r;

        bit                started;
        bit                have_sample;
        bit                usage_present;
        logic [TIME_W-1:0] last_time;
        logic [TIME_W-1:0] last_cpu;
        logic [Q_W-1:0]    usage_avg;
        logic [Q_W-1:0]    soft_now;
        vote_t             votes [VOTE_WINDOW];
        int unsigned       vote_head;
        int unsigned       vote_count;
        int                vote_sum;

        tick_result_t      expected_ticks [$];
        int unsigned       errors;

        function new();
            hard_limit_r  = HARD_LIMIT_RST;
            min_limit_r   = MIN_LIMIT_RST;
            smoothing_r   = SMOOTHING_FACTOR_RST;
            lower_bound_r = LOWER_BOUND_RST;
            upper_bound_r = UPPER_BOUND_RST;
            threshold_r   = VOTE_THRESHOLD_RST;
            reclaim_r     = 1'b0;
            start_time_r  = START_TIME_RST;
            started       = 1'b0;
            have_sample   = 1'b0;
            usage_present = 1'b0;
            last_time     = '0;
            last_cpu      = '0;
            usage_avg     = '0;
            soft_now      = HARD_LIMIT_RST;
            foreach (votes[i]) votes[i] = VOTE_KEEP;
            vote_head     = 0;
            vote_count    = 0;
            vote_sum      = 0;
            errors        = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
            case (index)
                REG_HARD_LIMIT:
                begin
                    hard_limit_r = value[Q_W-1:0];
                    soft_now     = value[Q_W-1:0];
                end
                REG_MIN_LIMIT:        min_limit_r   = value[Q_W-1:0];
                REG_SMOOTHING_FACTOR: smoothing_r   = value[SF_W-1:0];
                REG_LOWER_BOUND:      lower_bound_r = value[Q_W-1:0];
                REG_UPPER_BOUND:      upper_bound_r = value[Q_W-1:0];
                REG_VOTE_THRESHOLD:   threshold_r   = value[THR_W-1:0];
                REG_RECLAIM_ENABLE:   reclaim_r     = value[0];
                REG_START_TIME:       start_time_r  = value[TIME_W-1:0];
                default: ;
            endcase
        endfunction

        // (num << 8) / den, saturated to the Q8.8 range; a zero divisor saturates.
        function logic [Q_W-1:0] sat_quotient(logic [TIME_W-1:0] num, logic [TIME_W-1:0] den);
            logic [TIME_W+FRAC_W-1:0] q;
            if (den == '0) return '1;
            q = {num, {FRAC_W{1'b0}}} / (TIME_W+FRAC_W)'(den);
            return (q > 'hFFFF) ? '1 : q[Q_W-1:0];
        endfunction

        function void note_tick(tick_t t);
            tick_result_t      want;
            logic [TIME_W-1:0] dt;
            logic [TIME_W-1:0] dc;
            logic [Q_W-1:0]    usage;
            logic [Q_W-1:0]    ratio;
            logic [Q_W-1:0]    proposal;
            logic [63:0]       weight;
            logic [63:0]       acc;
            logic [63:0]       scaled;
            logic [63:0]       floor_lim;
            vote_t             vote;
            vote_t             old;
            bit                decided;

            want.limit_changed  = 1'b0;
            want.change_refused = 1'b0;
            if (!started && t.now_time >= start_time_r) started = 1'b1;

            if (!started) begin
                want.tick_status = TICK_NOT_STARTED;
            end else if (!t.read_ok) begin
                want.tick_status = TICK_READ_FAILED;
            end else if (!have_sample) begin
                have_sample      = 1'b1;
                last_time        = t.now_time;
                last_cpu         = t.total_cpu;
                want.tick_status = TICK_PRIMING;
            end else begin
                // Both deltas wrap modulo 2^48 through the vector width.
                dt        = t.now_time - last_time;
                dc        = t.total_cpu - last_cpu;
                usage     = sat_quotient(dc, dt);
                last_time = t.now_time;
                last_cpu  = t.total_cpu;

                if (usage_present) begin
                    weight    = (smoothing_r > SF_ONE) ? 64'(SF_ONE) : 64'(smoothing_r);
                    acc       = weight * usage + (64'd65536 - weight) * usage_avg + 64'd32768;
                    usage_avg = acc[31:16];
                end else begin
                    usage_avg     = hard_limit_r;
                    usage_present = 1'b1;
                end

                ratio = sat_quotient(TIME_W'(usage_avg), TIME_W'(soft_now));
                if (ratio < lower_bound_r)      vote = VOTE_DEC;
                else if (ratio > upper_bound_r) vote = VOTE_INC;
                else                            vote = VOTE_KEEP;

                if (vote_count < VOTE_WINDOW) begin
                    votes[VOTE_IDX_W'((vote_head + vote_count) % VOTE_WINDOW)] = vote;
                    vote_count++;
                    if (vote == VOTE_INC)      vote_sum++;
                    else if (vote == VOTE_DEC) vote_sum--;
                end

                if (vote_count >= VOTE_WINDOW) begin
                    decided  = 1'b0;
                    proposal = soft_now;
                    if (vote_sum > int'(threshold_r)) begin
                        scaled   = (64'(soft_now) * INCREASE_COEF) >> FRAC_W;
                        proposal = (scaled > hard_limit_r) ? hard_limit_r : scaled[Q_W-1:0];
                        decided  = 1'b1;
                    end else if (vote_sum < -int'(threshold_r)) begin
                        floor_lim = (min_limit_r < hard_limit_r) ? 64'(min_limit_r)
                                                                 : 64'(hard_limit_r);
                        scaled    = (64'(soft_now) * DECREASE_COEF) >> FRAC_W;
                        proposal  = (scaled < floor_lim) ? floor_lim[Q_W-1:0]
                                                         : scaled[Q_W-1:0];
                        decided   = 1'b1;
                    end

                    if (decided) begin
                        // A decision clears the window even when nothing changes.
                        vote_count = 0;
                        vote_head  = 0;
                        vote_sum   = 0;
                        if (proposal != soft_now) begin
                            if (!reclaim_r || t.change_accepted) begin
                                soft_now           = proposal;
                                want.limit_changed = 1'b1;
                            end else begin
                                want.change_refused = 1'b1;
                            end
                        end
                    end else begin
                        old = votes[VOTE_IDX_W'(vote_head)];
                        if (old == VOTE_INC)      vote_sum--;
                        else if (old == VOTE_DEC) vote_sum++;
                        vote_head = (vote_head + 1) % VOTE_WINDOW;
                        vote_count--;
                    end
                end
                want.tick_status = TICK_EVALUATED;
            end

            want.soft_limit     = soft_now;
            want.smoothed_usage = usage_present ? usage_avg : '0;
            want.usage_valid    = usage_present;
            expected_ticks.push_back(want);
        endfunction

        function void compare_field(string name, logic [Q_W-1:0] want_v, logic [Q_W-1:0] got_v);
            if (got_v !== want_v) begin
                errors++;
                $display("%0t: %s expected %0h actual %0h", $time, name, want_v, got_v);
            end
        endfunction

        function void check_result(tick_result_t got);
            tick_result_t want;
            if (expected_ticks.size() == 0) begin
                errors++;
                $display("%0t: result transfer expected none actual soft_limit %0h",
                         $time, got.soft_limit);
                return;
            end
            want = expected_ticks[0];
            expected_ticks.delete(0);
            compare_field("soft_limit", want.soft_limit, got.soft_limit);
            compare_field("smoothed_usage", want.smoothed_usage, got.smoothed_usage);
            compare_field("usage_valid", want.usage_valid, got.usage_valid);
            compare_field("limit_changed", want.limit_changed, got.limit_changed);
            compare_field("change_refused", want.change_refused, got.change_refused);
            compare_field("tick_status", want.tick_status, got.tick_status);
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic [TIME_W-1:0]     now_time;
    logic [TIME_W-1:0]     total_cpu;
    logic                  read_ok;
    logic                  change_accepted;
    logic                  out_valid;
    logic                  out_stall;
    logic [Q_W-1:0]        soft_limit;
    logic [Q_W-1:0]        smoothed_usage;
    logic                  usage_valid;
    logic                  limit_changed;
    logic                  change_refused;
    logic [1:0]            tick_status;

    soft_limit_tracker tracker;

    // When set, neither side inserts gaps, so ticks run back to back.
    bit                quiet_phase;

    // Running timestamp and CPU counter of the synthetic job.
    logic [TIME_W-1:0] now_t;
    logic [TIME_W-1:0] cpu_t;

    cpu_soft_limit_vote_regulator_top i_dut (.*);

    initial begin
        clk = 1'b0;
        forever #HALF_PERIOD clk = ~clk;
    end

    function automatic int unsigned draw_gap();
        return quiet_phase ? 0 : $urandom_range(0, 15);
    endfunction

    function automatic logic [TIME_W-1:0] random_stamp();
        return {16'($urandom), 32'($urandom)};
    endfunction

    // Transfers are observed at the rising edge. Results are checked before the tick of
    // the same edge is noted, so a result can never be matched against its own tick.
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && !out_stall)
                tracker.check_result('{soft_limit, smoothed_usage, usage_valid, limit_changed,
                                       change_refused, tick_status_t'(tick_status)});
            if (in_valid && !in_stall)
                tracker.note_tick('{now_time, total_cpu, read_ok, change_accepted});
        end
    end

    // The receiver draws a hold time after every result transfer. It raises stall at
    // once, waits until the next result shows up, and holds that result for the drawn
    // number of cycles, so stalls land on fast and slow ticks alike.
    initial begin : result_sink
        int unsigned hold;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (out_valid && !out_stall) begin
                hold = draw_gap();
                if (hold != 0) begin
                    @(negedge clk);
                    out_stall = 1'b1;
                    do @(posedge clk); while (!out_valid);
                    repeat (hold) @(negedge clk);
                    out_stall = 1'b0;
                end
            end
        end
    end

    // The watchdog ends the run if neither channel moves for too long.
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        @(posedge rst_n);
        while (quiet < IDLE_LIMIT) begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
            else quiet++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // Offers one tick after a random gap and returns at the edge where it transfers.
    // Valid stays high afterwards; the next call either replaces the payload at the
    // following falling edge or lowers valid for its own gap.
    task automatic send_tick(input logic [TIME_W-1:0] t_now, input logic [TIME_W-1:0] t_cpu,
                             input logic ok, input logic consent);
        int unsigned gap;
        gap = draw_gap();
        @(negedge clk);
        if (gap != 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        now_time        = t_now;
        total_cpu       = t_cpu;
        read_ok         = ok;
        change_accepted = consent;
        in_valid        = 1'b1;
        do @(posedge clk); while (in_stall);
    endtask

    // Stops offering ticks and waits until every queued result has come back. Each
    // tick yields exactly one result, so the block is idle once the queue is empty.
    task automatic drain_results();
        @(negedge clk);
        in_valid = 1'b0;
        while (tracker.expected_ticks.size() != 0) @(posedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = index;
        cfg_data  = value;
        tracker.write_reg(index, value);
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    // Phase settings. The first three hold the extremes: everything at zero with
    // reclaim on, everything at its maximum, and a smoothing factor above one together
    // with a threshold the window can never exceed and a floor above the hard limit.
    // The rest are random but kept in a range where decisions happen often. In random
    // phases hard_limit is sometimes left alone so the soft limit carries over.
    task automatic apply_settings(input int unsigned kind);
        logic [Q_W-1:0]    hard;
        logic [Q_W-1:0]    floor_v;
        logic [SF_W-1:0]   weight;
        logic [Q_W-1:0]    lo;
        logic [Q_W-1:0]    hi;
        logic [THR_W-1:0]  thr;
        logic              reclaim;
        logic [TIME_W-1:0] start;
        case (kind)
            0:
            begin
                hard = '0; floor_v = '0; weight = '0; lo = '0; hi = '0;
                thr = '0; reclaim = 1'b1; start = '0;
            end
            1:
            begin
                hard = '1; floor_v = '1; weight = SF_ONE; lo = '1; hi = '1;
                thr = 5'd16; reclaim = 1'b0; start = '1;
            end
            2:
            begin
                hard = 16'd1024; floor_v = 16'd2048; weight = '1; lo = 16'd128; hi = 16'd230;
                thr = '1; reclaim = 1'b0; start = random_stamp();
            end
            default:
            begin
                hard    = Q_W'($urandom_range(64, 8192));
                floor_v = $urandom_range(0, 1) ? Q_W'($urandom_range(0, hard))
                                               : Q_W'($urandom_range(0, 65535));
                weight  = ($urandom_range(0, 7) == 0) ? SF_W'($urandom_range(0, 131071))
                                                      : SF_W'($urandom_range(3000, 65536));
                lo      = Q_W'($urandom_range(64, 200));
                hi      = lo + Q_W'($urandom_range(0, 120));
                thr     = THR_W'($urandom_range(0, 8));
                reclaim = 1'($urandom_range(0, 1));
                start   = random_stamp();
            end
        endcase
        if (kind < 3 || $urandom_range(0, 1)) write_reg(REG_HARD_LIMIT, hard);
        write_reg(REG_MIN_LIMIT, floor_v);
        write_reg(REG_SMOOTHING_FACTOR, weight);
        write_reg(REG_LOWER_BOUND, lo);
        write_reg(REG_UPPER_BOUND, hi);
        write_reg(REG_VOTE_THRESHOLD, thr);
        write_reg(REG_RECLAIM_ENABLE, reclaim);
        write_reg(REG_START_TIME, start);
    endtask

    // Random load. Ticks come in runs of steady load relative to the current soft
    // limit (well above the upper bound, well below the lower bound, in between, idle
    // or random), so the window fills with agreeing votes and decisions are reached.
    // A few ticks are noise: failed readings, a zero time step, a CPU counter that
    // steps back, or fully random stamps. Failed readings do not count toward the goal.
    task automatic run_load_phase(input int unsigned goal);
        int unsigned       good;
        int unsigned       run_len;
        int unsigned       regime;
        int unsigned       k;
        int unsigned       roll;
        logic [31:0]       load;
        logic [TIME_W-1:0] dt;
        logic              ok;
        logic              consent;
        good = 0;
        while (good < goal) begin
            regime  = $urandom_range(0, 5);
            run_len = $urandom_range(8, 40);
            for (k = 0; k < run_len && good < goal; k++) begin
                case (regime)
                    0:       load = 32'(tracker.soft_now) * 2 + $urandom_range(0, 255);
                    1:       load = 32'(tracker.soft_now) / 8;
                    2:       load = (32'(tracker.soft_now) * 3) / 4;
                    3:       load = $urandom_range(0, 65535);
                    4:       load = '0;
                    default: load = 32'(tracker.soft_now) + $urandom_range(0, 64);
                endcase
                roll    = $urandom_range(0, 99);
                ok      = 1'b1;
                consent = 1'($urandom_range(0, 1));
                dt      = TIME_W'($urandom_range(100, 100000));
                now_t   = now_t + dt;
                cpu_t   = cpu_t + ((dt * TIME_W'(load)) >> FRAC_W);
                if (roll < 4) begin
                    ok = 1'b0;
                end else if (roll < 6) begin
                    now_t = now_t - dt;
                end else if (roll < 8) begin
                    cpu_t = cpu_t - TIME_W'($urandom_range(1, 1000000));
                end else if (roll < 10) begin
                    now_t = random_stamp();
                    cpu_t = random_stamp();
                end else if (roll == 99) begin
                    // Hold the next tick back until the block has nothing left to say.
                    drain_results();
                end
                send_tick(now_t, cpu_t, ok, consent);
                if (ok) good++;
            end
        end
    endtask

    initial begin : stimulus
        int unsigned n;
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = REG_HARD_LIMIT;
        cfg_data        = '0;
        in_valid        = 1'b0;
        now_time        = '0;
        total_cpu       = '0;
        read_ok         = 1'b0;
        change_accepted = 1'b0;
        quiet_phase     = 1'b0;
        tracker         = new();
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        // Directed part. The start time sits at the top of the time range, so only the
        // largest stamp starts the regulator. Then come a failed reading, the priming
        // sample at the maximum stamps, a step that wraps both counters, a zero time
        // step, a CPU counter that runs backwards, a tick with no CPU used, a huge time
        // step, a failed reading after the start, and time running backwards.
        write_reg(REG_START_TIME, '1);
        send_tick('0, '0, 1'b1, 1'b0);
        send_tick(48'h7FFF_FFFF_FFFF, random_stamp(), 1'b1, 1'b1);
        send_tick(48'hFFFF_FFFF_FFFE, '0, 1'b0, 1'b1);
        send_tick('1, '0, 1'b0, 1'b0);
        send_tick('1, '1, 1'b1, 1'b1);
        send_tick('0, '0, 1'b1, 1'b0);
        send_tick('0, '0, 1'b1, 1'b1);
        send_tick(48'd1000, '1, 1'b1, 1'b0);
        send_tick(48'd2000, '1, 1'b1, 1'b1);
        send_tick(48'h8000_0000_07D0, 48'h5555_5555_5555, 1'b1, 1'b0);
        send_tick(48'd500, 48'hAAAA_AAAA_AAAA, 1'b0, 1'b1);
        send_tick(48'd500, 48'h2AAA_AAAA_AAAA, 1'b1, 1'b1);

        // A steady heavy load fills the window with increase votes. With the soft
        // limit already at the hard limit the decision offers no change but still
        // clears the window.
        now_t = 48'd500;
        cpu_t = 48'h2AAA_AAAA_AAAA;
        for (n = 0; n < 14; n++) begin
            now_t = now_t + 48'd10000;
            cpu_t = cpu_t + 48'd20000;
            send_tick(now_t, cpu_t, 1'b1, n[0]);
        end

        // Random phases, each under its own settings. Every third phase runs without
        // gaps on either side.
        for (n = 0; n < PHASE_COUNT; n++) begin
            drain_results();
            apply_settings(n);
            quiet_phase = (n % 3 == 1);
            run_load_phase(PHASE_TICKS);
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
